@@ hdl/b41_pkg.sv @@
// ----------------------------------------------------------------------------
// b41_pkg: shared types and constants for the base-41 identifier text parser
// Word layouts, status codes, character codes and the alphabet decode.
// ----------------------------------------------------------------------------
package b41_pkg;

    localparam int RADIX = 41;
    localparam int WORD_W = 32;
    localparam int GROUP_COUNT = 4;
    localparam int ACC_W = 38;

    localparam logic [7:0] TERM_CHAR = 8'h00;
    localparam logic [7:0] DASH_CHAR = 8'h2D;

    localparam logic [2:0] DIGITS_PER_GROUP = 3'd6;
    localparam logic [2:0] DIGIT_COUNT_SAT = 3'd7;
    localparam logic [1:0] LAST_GROUP = 2'd3;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    typedef struct packed {
        logic [7:0] text_char;
        logic [7:0] id_kind;
    } t_in_word;

    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [1:0]  parse_status;
    } t_out_word;

    typedef logic [GROUP_COUNT-1:0][WORD_W-1:0] t_group_words;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } t_digit;

    function automatic t_digit digit_of(input logic [7:0] ch);
        t_digit d;
        d.hit = 1'b1;
        d.value = 6'd0;
        case (ch) inside
            [8'h61:8'h68]: d.value = 6'(ch - 8'h61);
            8'h6B:         d.value = 6'd8;
            8'h6F:         d.value = 6'd9;
            [8'h70:8'h74]: d.value = 6'(ch - 8'h70) + 6'd10;
            8'h79:         d.value = 6'd15;
            [8'h41:8'h48]: d.value = 6'(ch - 8'h41) + 6'd16;
            8'h4B:         d.value = 6'd24;
            8'h4C:         d.value = 6'd25;
            [8'h50:8'h54]: d.value = 6'(ch - 8'h50) + 6'd26;
            8'h59:         d.value = 6'd31;
            [8'h32:8'h39]: d.value = 6'(ch - 8'h32) + 6'd32;
            8'h30:         d.value = 6'd40;
            default:       d.hit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

@@ hdl/b41_pack_check.sv @@
// ----------------------------------------------------------------------------
// b41_pack_check: result assembly
// Packs the four group words big-endian and tests the checksum byte.
// ----------------------------------------------------------------------------
module b41_pack_check (
    input  b41_pkg::t_group_words i_words,
    input  logic [7:0]            i_kind,
    input  logic                  i_complete,
    output b41_pkg::t_out_word    o_result
);

    logic [3:0][7:0] word_sum;
    logic [7:0]      total;
    logic [127:0]    id_value;

    always_comb begin
        for (int g = 0; g < b41_pkg::GROUP_COUNT; g++) begin
            word_sum[g] = i_words[g][31:24] + i_words[g][23:16] + i_words[g][15:8];
            // byte 7 is the low byte of word 1: leave it out
            if (g != 1) begin
                word_sum[g] = word_sum[g] + i_words[g][7:0];
            end
        end
    end

    assign total = i_kind + word_sum[0] + word_sum[1] + word_sum[2] + word_sum[3];
    assign id_value = {i_words[0], i_words[1], i_words[2], i_words[3]};

    always_comb begin
        if (!i_complete) begin
            o_result.id_high = 64'd0;
            o_result.id_low = 64'd0;
            o_result.parse_status = b41_pkg::STATUS_MALFORMED;
        end else begin
            o_result.id_high = id_value[127:64];
            o_result.id_low = id_value[63:0];
            o_result.parse_status = (total == i_words[1][7:0]) ? b41_pkg::STATUS_OK
                                                                : b41_pkg::STATUS_CHECKSUM;
        end
    end

endmodule

@@ hdl/base41_id_text_parser_unit.sv @@
// ----------------------------------------------------------------------------
// base41_id_text_parser_unit: base-41 identifier text parser
// Path: a terminator word goes through the input register, then the result
// register, and waits in the input register while the output is stalled.
// Throughput: one character word per cycle (a terminator waits on a stalled
// output), set by the multiply-add by 41 on the group word feeding itself.
// Reset: synchronous active low; clears parse state and both valid flags.
// ----------------------------------------------------------------------------
module base41_id_text_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  b41_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output b41_pkg::t_out_word  o_out_word
);

    logic                  r_in_valid;
    b41_pkg::t_in_word     r_in;
    logic                  r_out_valid;
    b41_pkg::t_out_word    r_out;

    b41_pkg::t_group_words r_words, n_words;
    logic [1:0]            r_group_index, n_group_index;
    logic [2:0]            r_digit_count, n_digit_count;
    logic                  r_error, n_error;

    logic                  is_term;
    logic                  out_free;
    logic                  fire;
    logic                  accept_in;
    logic                  complete;
    b41_pkg::t_digit       digit;
    logic [b41_pkg::ACC_W-1:0] acc;
    b41_pkg::t_out_word    result;

    assign is_term = (r_in.text_char == b41_pkg::TERM_CHAR);
    assign out_free = !r_out_valid || !i_out_stall;
    assign fire = r_in_valid && (!is_term || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign accept_in = i_in_valid && !o_in_stall;

    assign complete = !r_error && (r_digit_count == b41_pkg::DIGITS_PER_GROUP)
                      && (r_group_index == b41_pkg::LAST_GROUP);

    assign digit = b41_pkg::digit_of(r_in.text_char);
    assign acc = b41_pkg::ACC_W'(r_words[r_group_index])
                 * b41_pkg::ACC_W'(b41_pkg::RADIX)
                 + b41_pkg::ACC_W'(digit.value);

    b41_pack_check u_pack_check (
        .i_words    (r_words),
        .i_kind     (r_in.id_kind),
        .i_complete (complete),
        .o_result   (result)
    );

    always_comb begin
        n_words = r_words;
        n_group_index = r_group_index;
        n_digit_count = r_digit_count;
        n_error = r_error;
        if (fire) begin
            if (is_term) begin
                n_words = '0;
                n_group_index = 2'd0;
                n_digit_count = 3'd0;
                n_error = 1'b0;
            end else if (!r_error) begin
                if (r_in.text_char == b41_pkg::DASH_CHAR) begin
                    if (r_digit_count != b41_pkg::DIGITS_PER_GROUP
                        || r_group_index == b41_pkg::LAST_GROUP) begin
                        n_error = 1'b1;
                    end else begin
                        n_group_index = r_group_index + 2'd1;
                        n_digit_count = 3'd0;
                    end
                end else if (!digit.hit) begin
                    n_error = 1'b1;
                end else begin
                    if (r_digit_count != b41_pkg::DIGIT_COUNT_SAT) begin
                        n_digit_count = r_digit_count + 3'd1;
                    end
                    if (acc[b41_pkg::ACC_W-1:b41_pkg::WORD_W] != '0) begin
                        n_error = 1'b1;
                    end else begin
                        n_words[r_group_index] = acc[b41_pkg::WORD_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_words <= '0;
            r_group_index <= 2'd0;
            r_digit_count <= 3'd0;
            r_error <= 1'b0;
        end else begin
            r_words <= n_words;
            r_group_index <= n_group_index;
            r_digit_count <= n_digit_count;
            r_error <= n_error;
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire && is_term) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in <= i_in_word;
        end
        if (fire && is_term) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out;

endmodule

@@ dv/tb_base41_id_text_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_base41_id_text_parser_unit: testbench for the base-41 identifier parser
// Feeds identifier texts one character word at a time: a short table of
// hand-picked malformed texts first, then random texts. Most random texts
// are well formed, and many carry a matching check byte. The rest are
// damaged, overflowing or noise. Both sides idle in random bursts. An
// in-bench parser predicts the result words of the random texts, the table
// gives its own, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb_base41_id_text_parser_unit;

    localparam int N_CHARS = 1700;
    localparam int CALM_TAIL = 250;
    localparam int CHECK_BYTE = 7;
    localparam logic [8*41-1:0] SYMBOLS = "abcdefghkopqrstyABCDEFGHKLPQRSTY234567890";

    typedef struct packed {
        b41_pkg::t_in_word  word;
        logic               typed;
        b41_pkg::t_out_word want;
    } t_plan_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    b41_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    b41_pkg::t_out_word out_word;

    logic [31:0] acc_words [4];
    logic [1:0]  acc_group;
    logic [2:0]  acc_digits;
    logic        acc_bad;

    b41_pkg::t_out_word pending_ids [$];
    int        mismatches = 0;
    int        chars_fed = 0;
    int        stall_left = 0;
    logic      calm = 1'b0;

    base41_id_text_parser_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #10 clk = ~clk;

    function automatic int symbol_value(input logic [7:0] ch);
        int k;
        for (k = 0; k < b41_pkg::RADIX; k++) begin
            if (SYMBOLS[8*(b41_pkg::RADIX-1-k) +: 8] == ch) return k;
        end
        return -1;
    endfunction

    function automatic logic [7:0] symbol_char(input int v);
        return SYMBOLS[8*(b41_pkg::RADIX-1-v) +: 8];
    endfunction

    function automatic logic [7:0] check_sum(input logic [7:0] start, input logic [127:0] value);
        logic [7:0] sum;
        int b;
        sum = start;
        for (b = 0; b < 16; b++) begin
            if (b != CHECK_BYTE) sum += value[127-8*b -: 8];
        end
        return sum;
    endfunction

    function automatic t_plan_row plan_row(input logic [7:0] ch, input logic [7:0] kind,
                                           input logic typed, input logic [1:0] status);
        t_plan_row r;
        r.word = b41_pkg::t_in_word'{ch, kind};
        r.typed = typed;
        r.want = b41_pkg::t_out_word'{64'd0, 64'd0, status};
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input b41_pkg::t_out_word want,
                                          input b41_pkg::t_out_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): want %h %h %0d, got %h %h %0d", what,
                     want.id_high, want.id_low, want.parse_status,
                     got.id_high, got.id_low, got.parse_status);
        end
    endfunction

    task automatic clear_parse();
        int g;
        for (g = 0; g < b41_pkg::GROUP_COUNT; g++) acc_words[g] = '0;
        acc_group = '0;
        acc_digits = '0;
        acc_bad = 1'b0;
    endtask

    task automatic parse_char(input b41_pkg::t_in_word w, output logic ignored,
                              output logic emits, output b41_pkg::t_out_word res);
        logic [127:0] value;
        logic [37:0]  acc;
        int           d;
        ignored = 1'b0;
        emits = 1'b0;
        res = '0;
        if (w.text_char == b41_pkg::TERM_CHAR) begin
            emits = 1'b1;
            if (acc_bad || acc_digits != b41_pkg::DIGITS_PER_GROUP
                || acc_group != b41_pkg::LAST_GROUP) begin
                res.parse_status = b41_pkg::STATUS_MALFORMED;
            end else begin
                value = {acc_words[0], acc_words[1], acc_words[2], acc_words[3]};
                res.id_high = value[127:64];
                res.id_low = value[63:0];
                res.parse_status = (check_sum(w.id_kind, value) ==
                                    value[127-8*CHECK_BYTE -: 8]) ? b41_pkg::STATUS_OK
                                                                  : b41_pkg::STATUS_CHECKSUM;
            end
            clear_parse();
        end else if (acc_bad) begin
            ignored = 1'b1;
        end else if (w.text_char == b41_pkg::DASH_CHAR) begin
            if (acc_digits != b41_pkg::DIGITS_PER_GROUP
                || acc_group == b41_pkg::LAST_GROUP) begin
                acc_bad = 1'b1;
            end else begin
                acc_group++;
                acc_digits = '0;
            end
        end else begin
            d = symbol_value(w.text_char);
            if (d < 0) begin
                acc_bad = 1'b1;
            end else begin
                acc = 38'(acc_words[acc_group]) * 38'(b41_pkg::RADIX) + 38'(d);
                if (acc_digits < b41_pkg::DIGIT_COUNT_SAT) acc_digits++;
                if (acc[37:32] != '0) acc_bad = 1'b1;
                else acc_words[acc_group] = acc[31:0];
            end
        end
    endtask

    task automatic send_char(input b41_pkg::t_in_word w, input logic typed,
                             input b41_pkg::t_out_word typed_want);
        logic               ignored;
        logic               emits;
        b41_pkg::t_out_word want;
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        parse_char(w, ignored, emits, want);
        if (emits) pending_ids.push_back(typed ? typed_want : want);
        if (!ignored) chars_fed++;
    endtask

    task automatic send_random_text();
        b41_pkg::t_in_word text [$];
        logic [31:0]  words [4];
        logic [127:0] value;
        logic [7:0]   kind;
        int           flaw;
        int           d;
        int           pos;
        int           g;
        int           k;
        flaw = $urandom_range(0, 11);
        kind = 8'($urandom_range(0, 255));
        if (flaw == 11) begin
            repeat ($urandom_range(0, 12)) begin
                text.push_back(b41_pkg::t_in_word'{8'($urandom_range(1, 255)), 8'($urandom)});
            end
        end else begin
            for (g = 0; g < b41_pkg::GROUP_COUNT; g++) begin
                words[g] = '0;
                for (k = 0; k < 6; k++) begin
                    // keep the lead digit small so most groups fit in 32 bits
                    if (k == 0) begin
                        d = ($urandom_range(0, 15) == 0) ? $urandom_range(37, 40)
                                                         : $urandom_range(0, 36);
                    end else begin
                        d = $urandom_range(0, b41_pkg::RADIX - 1);
                    end
                    words[g] = words[g] * b41_pkg::RADIX + d;
                    text.push_back(b41_pkg::t_in_word'{symbol_char(d), 8'($urandom)});
                end
                if (g < b41_pkg::GROUP_COUNT - 1) begin
                    text.push_back(b41_pkg::t_in_word'{b41_pkg::DASH_CHAR, 8'($urandom)});
                end
            end
            value = {words[0], words[1], words[2], words[3]};
            if ($urandom_range(0, 2) != 0) begin
                kind = value[127-8*CHECK_BYTE -: 8] - check_sum(8'd0, value);
            end
            pos = $urandom_range(0, text.size() - 1);
            case (flaw)
                7: begin
                    text[pos].text_char = 8'($urandom_range(1, 255));
                end
                8: begin
                    if ($urandom_range(0, 1) == 0) pos = text.size();
                    text.insert(pos, b41_pkg::t_in_word'{b41_pkg::DASH_CHAR, 8'($urandom)});
                end
                9: begin
                    text.delete(pos);
                end
                10: begin
                    text.insert(pos, b41_pkg::t_in_word'{
                                    symbol_char($urandom_range(0, b41_pkg::RADIX - 1)),
                                    8'($urandom)});
                end
                default: begin
                end
            endcase
        end
        text.push_back(b41_pkg::t_in_word'{b41_pkg::TERM_CHAR, kind});
        foreach (text[i]) send_char(text[i], 1'b0, '0);
    endtask

    always @(posedge clk) begin
        b41_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_ids.size() == 0) begin
                note_mismatch("unexpected result", '0, out_word);
            end else begin
                want = pending_ids.pop_front();
                if (out_word.id_high !== want.id_high || out_word.id_low !== want.id_low ||
                    out_word.parse_status !== want.parse_status) begin
                    note_mismatch("wrong result", want, out_word);
                end
            end
        end
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        #8000000;
        $display("tb_base41_id_text_parser_unit: done, errors");
        $finish;
    end

    initial begin
        t_plan_row plan [$];
        int        waited;
        clear_parse();
        plan.push_back(plan_row(b41_pkg::TERM_CHAR, 8'h00, 1'b1, b41_pkg::STATUS_MALFORMED));
        plan.push_back(plan_row(8'h78, 8'h00, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(b41_pkg::TERM_CHAR, 8'hFF, 1'b1, b41_pkg::STATUS_MALFORMED));
        plan.push_back(plan_row(b41_pkg::DASH_CHAR, 8'hFF, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(b41_pkg::TERM_CHAR, 8'h00, 1'b1, b41_pkg::STATUS_MALFORMED));
        repeat (6) plan.push_back(plan_row(8'h30, 8'hFF, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(b41_pkg::TERM_CHAR, 8'h80, 1'b1, b41_pkg::STATUS_MALFORMED));
        plan.push_back(plan_row(8'h61, 8'h00, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(8'hFF, 8'hFF, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(8'h59, 8'h00, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(b41_pkg::DASH_CHAR, 8'h00, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(b41_pkg::TERM_CHAR, 8'h7F, 1'b1, b41_pkg::STATUS_MALFORMED));
        repeat (7) plan.push_back(plan_row(8'h61, 8'h55, 1'b0, b41_pkg::STATUS_OK));
        plan.push_back(plan_row(b41_pkg::TERM_CHAR, 8'h01, 1'b1, b41_pkg::STATUS_MALFORMED));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (plan[i]) send_char(plan[i].word, plan[i].typed, plan[i].want);
        while (chars_fed < N_CHARS) begin
            calm = (chars_fed >= N_CHARS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
            send_random_text();
        end
        in_valid <= 1'b0;

        // drain, then allow the pipeline to settle
        waited = 0;
        while (pending_ids.size() != 0 && waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        foreach (pending_ids[i]) note_mismatch("missing result", pending_ids[i], '0);

        if (mismatches == 0) begin
            $display("tb_base41_id_text_parser_unit: done, clean");
        end else begin
            $display("tb_base41_id_text_parser_unit: done, errors");
        end
        $finish;
    end

endmodule
